@@ sv/akph_pkg.sv @@
package akph_pkg;

    // Word storage and table sizes.
    localparam int MAX_WORD_LENGTH = 9;
    localparam int TABLE_SLOTS     = 71;
    localparam int LEN_W           = $clog2(MAX_WORD_LENGTH + 2);
    localparam int SLOT_W          = $clog2(TABLE_SLOTS);
    localparam int HASH_W          = 10;
    localparam int WEIGHT_W        = 7;
    localparam int KEY_W           = 8 * MAX_WORD_LENGTH;

    // The length counter stops one past the longest stored word.
    localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_WORD_LENGTH + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD_LENGTH);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef logic [LEN_W-1:0]  length_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [7:0]        char_t;
    typedef char_t [MAX_WORD_LENGTH-1:0] word_t;
    typedef logic [KEY_W-1:0]  key_t;

    // Hash weight of a letter, indexed by its position in the alphabet.
    function automatic logic signed [WEIGHT_W-1:0] letter_weight(input logic [4:0] idx);
        logic signed [WEIGHT_W-1:0] w;
        case (idx)
            5'd0:    w = 7'sd0;
            5'd1:    w = 7'sd49;
            5'd2:    w = 7'sd0;
            5'd3:    w = -7'sd7;
            5'd4:    w = -7'sd20;
            5'd5:    w = 7'sd18;
            5'd6:    w = -7'sd2;
            5'd7:    w = -7'sd38;
            5'd8:    w = 7'sd33;
            5'd9:    w = 7'sd0;
            5'd10:   w = -7'sd9;
            5'd11:   w = 7'sd9;
            5'd12:   w = 7'sd29;
            5'd13:   w = -7'sd9;
            5'd14:   w = 7'sd6;
            5'd15:   w = 7'sd26;
            5'd16:   w = 7'sd0;
            5'd17:   w = 7'sd8;
            5'd18:   w = 7'sd1;
            5'd19:   w = 7'sd1;
            5'd20:   w = -7'sd9;
            5'd21:   w = 7'sd0;
            5'd22:   w = 7'sd56;
            5'd23:   w = -7'sd28;
            5'd24:   w = 7'sd11;
            5'd25:   w = 7'sd0;
            default: w = 7'sd0;
        endcase
        return w;
    endfunction

    // Keyword held in each slot, right-justified with zero bytes above it.
    // Empty slots hold all zeros and never match a word of two or more letters.
    function automatic key_t keyword_rom(input slot_t slot);
        key_t k;
        case (slot)
            7'd0:    k = KEY_W'("else");
            7'd1:    k = KEY_W'("exit");
            7'd2:    k = KEY_W'("end");
            7'd3:    k = KEY_W'("at");
            7'd4:    k = KEY_W'("then");
            7'd5:    k = KEY_W'("range");
            7'd6:    k = KEY_W'("abs");
            7'd7:    k = KEY_W'("do");
            7'd8:    k = KEY_W'("exception");
            7'd9:    k = KEY_W'("delay");
            7'd10:   k = KEY_W'("use");
            7'd11:   k = KEY_W'("xor");
            7'd12:   k = KEY_W'("select");
            7'd14:   k = KEY_W'("declare");
            7'd15:   k = KEY_W'("type");
            7'd16:   k = KEY_W'("array");
            7'd17:   k = KEY_W'("limited");
            7'd18:   k = KEY_W'("subtype");
            7'd19:   k = KEY_W'("elsif");
            7'd20:   k = KEY_W'("case");
            7'd21:   k = KEY_W'("generic");
            7'd22:   k = KEY_W'("and");
            7'd23:   k = KEY_W'("not");
            7'd24:   k = KEY_W'("renames");
            7'd25:   k = KEY_W'("package");
            7'd26:   k = KEY_W'("null");
            7'd27:   k = KEY_W'("separate");
            7'd28:   k = KEY_W'("terminate");
            7'd29:   k = KEY_W'("raise");
            7'd30:   k = KEY_W'("entry");
            7'd31:   k = KEY_W'("reverse");
            7'd32:   k = KEY_W'("task");
            7'd34:   k = KEY_W'("all");
            7'd35:   k = KEY_W'("constant");
            7'd36:   k = KEY_W'("delta");
            7'd37:   k = KEY_W'("accept");
            7'd38:   k = KEY_W'("digits");
            7'd39:   k = KEY_W'("return");
            7'd40:   k = KEY_W'("abort");
            7'd41:   k = KEY_W'("record");
            7'd42:   k = KEY_W'("in");
            7'd43:   k = KEY_W'("access");
            7'd44:   k = KEY_W'("or");
            7'd45:   k = KEY_W'("function");
            7'd46:   k = KEY_W'("goto");
            7'd47:   k = KEY_W'("others");
            7'd48:   k = KEY_W'("rem");
            7'd49:   k = KEY_W'("procedure");
            7'd50:   k = KEY_W'("out");
            7'd51:   k = KEY_W'("private");
            7'd52:   k = KEY_W'("is");
            7'd53:   k = KEY_W'("mod");
            7'd54:   k = KEY_W'("of");
            7'd56:   k = KEY_W'("pragma");
            7'd57:   k = KEY_W'("for");
            7'd58:   k = KEY_W'("new");
            7'd59:   k = KEY_W'("when");
            7'd60:   k = KEY_W'("with");
            7'd61:   k = KEY_W'("begin");
            7'd63:   k = KEY_W'("while");
            7'd67:   k = KEY_W'("loop");
            7'd69:   k = KEY_W'("if");
            7'd70:   k = KEY_W'("body");
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic is_lower(input char_t c);
        return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
    endfunction

endpackage

@@ sv/ada_keyword_perfect_hash_unit.sv @@
// A finished word goes to the lookup stage, then the result register. Throughput: one
// character beat per cycle while in_ready is high; the input path is a buffer write and a
// counter step, and the lookup is a single registered pass through the hash and keyword ROM.
// Reset (rst_n, asynchronous, active low) clears the length counter and both valid flags;
// the character buffer and payload registers are not reset.
module ada_keyword_perfect_hash_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            character,
    input  logic                  last_char,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_reserved,
    output logic [6:0]            keyword_slot
);

    // Character collection state.
    akph_pkg::word_t   buf_reg;
    akph_pkg::length_t len_reg;
    akph_pkg::length_t len_next;
    akph_pkg::length_t len_inc;
    akph_pkg::char_t   char_fold;
    akph_pkg::word_t   word_merged;

    // Lookup stage: a finished word waiting to be classified.
    logic              s1_valid_reg;
    akph_pkg::word_t   s1_word_reg;
    akph_pkg::length_t s1_len_reg;
    logic              s1_adv;

    // Result register.
    logic              out_valid_reg;
    logic              is_reserved_reg;
    akph_pkg::slot_t   slot_reg;

    logic              in_fire;

    // Lookup logic.
    logic                          len_ok;
    akph_pkg::length_t             idx_last;
    akph_pkg::length_t             idx_prev;
    akph_pkg::char_t               c_first;
    akph_pkg::char_t               c_last;
    akph_pkg::char_t               c_prev;
    logic                          letters_ok;
    logic [7:0]                    prev_off;
    logic signed [akph_pkg::WEIGHT_W-1:0] w_first;
    logic signed [akph_pkg::WEIGHT_W-1:0] w_last;
    logic signed [akph_pkg::HASH_W-1:0]   hash;
    logic                          hash_ok;
    akph_pkg::slot_t               slot;
    akph_pkg::key_t                left_word;
    akph_pkg::key_t                right_word;
    akph_pkg::length_t             pad_bytes;
    logic                          hit;

    // Handshake: the lookup stage moves on whenever the result register is free.
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // Fold upper case to lower case; other bytes pass unchanged.
    always_comb
    begin
        if ((character >= akph_pkg::CHAR_UPPER_A) && (character <= akph_pkg::CHAR_UPPER_Z))
        begin
            char_fold = character + akph_pkg::CASE_OFFSET;
        end
        else
        begin
            char_fold = character;
        end
    end

    // Saturating length and the buffer as it looks with this beat's character stored.
    always_comb
    begin
        if (len_reg <= akph_pkg::LEN_MAX)
        begin
            len_inc = len_reg + akph_pkg::length_t'(1);
        end
        else
        begin
            len_inc = len_reg;
        end
        word_merged = buf_reg;
        if (len_reg < akph_pkg::LEN_MAX)
        begin
            word_merged[len_reg] = char_fold;
        end
        len_next = last_char ? '0 : len_inc;
    end

    // Length counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (in_fire)
        begin
            len_reg <= len_next;
        end
    end

    // Character buffer; positions past the current length are never looked at.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_reg <= word_merged;
        end
    end

    // Lookup stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire && last_char)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Snapshot of the finished word, so the next word can start at once.
    always_ff @(posedge clk)
    begin
        if (in_fire && last_char)
        begin
            s1_word_reg <= word_merged;
            s1_len_reg  <= len_inc;
        end
    end

    // Pick the hashed characters and check that they are letters.
    always_comb
    begin
        len_ok   = (s1_len_reg >= akph_pkg::LEN_MIN) && (s1_len_reg <= akph_pkg::LEN_MAX);
        idx_last = s1_len_reg - akph_pkg::length_t'(1);
        idx_prev = s1_len_reg - akph_pkg::length_t'(2);
        c_first  = s1_word_reg[0];
        c_last   = len_ok ? s1_word_reg[idx_last] : '0;
        c_prev   = len_ok ? s1_word_reg[idx_prev] : '0;
        letters_ok = akph_pkg::is_lower(c_first) && akph_pkg::is_lower(c_last)
                     && akph_pkg::is_lower(c_prev);
    end

    // Perfect hash: weight(first) + weight(last) + 2 * (second last - 'a') + length.
    always_comb
    begin
        prev_off = c_prev - akph_pkg::CHAR_LOWER_A;
        w_first  = akph_pkg::letter_weight(5'(c_first - akph_pkg::CHAR_LOWER_A));
        w_last   = akph_pkg::letter_weight(5'(c_last - akph_pkg::CHAR_LOWER_A));
        hash     = {{(akph_pkg::HASH_W - akph_pkg::WEIGHT_W){w_first[akph_pkg::WEIGHT_W-1]}},
                    w_first}
                 + {{(akph_pkg::HASH_W - akph_pkg::WEIGHT_W){w_last[akph_pkg::WEIGHT_W-1]}},
                    w_last}
                 + {1'b0, prev_off[akph_pkg::HASH_W-3:0], 1'b0}
                 + {{(akph_pkg::HASH_W - akph_pkg::LEN_W){1'b0}}, s1_len_reg};
        hash_ok  = !hash[akph_pkg::HASH_W-1]
                   && (hash < akph_pkg::HASH_W'(akph_pkg::TABLE_SLOTS));
        slot     = hash[akph_pkg::SLOT_W-1:0];
    end

    // Right-justify the word to line it up with the keyword ROM entry.
    // Since the first character is a letter, equal words also have equal lengths.
    always_comb
    begin
        for (int i = 0; i < akph_pkg::MAX_WORD_LENGTH; i++)
        begin
            left_word[8 * (akph_pkg::MAX_WORD_LENGTH - 1 - i) +: 8] = s1_word_reg[i];
        end
        pad_bytes  = len_ok ? (akph_pkg::LEN_MAX - s1_len_reg) : '0;
        right_word = left_word >> {pad_bytes, 3'b000};
        hit        = len_ok && letters_ok && hash_ok
                     && (right_word == akph_pkg::keyword_rom(slot));
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            is_reserved_reg <= hit;
            slot_reg        <= hit ? slot : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_reserved  = is_reserved_reg;
    assign keyword_slot = slot_reg;

    // A last character always leaves a word waiting in the lookup stage.
    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_char |=> s1_valid_reg)
        else $error("finished word did not enter the lookup stage");

    // The length counter never passes its saturation value.
    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= akph_pkg::LEN_SAT)
        else $error("length counter overran its saturation value");

    // An identifier result carries slot zero, and a keyword slot is in the table.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_reserved |-> keyword_slot == '0)
        else $error("identifier result with nonzero slot");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_reserved |-> keyword_slot < 7'(akph_pkg::TABLE_SLOTS))
        else $error("keyword slot outside the table");

    // A held word in the lookup stage keeps the length it was captured with.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_len_reg))
        else $error("stalled lookup stage lost its word");

endmodule
